// ===== src/sync_crc_frame_parser_top_assert.svh =====
// Assertion macros used by the parser module
`ifndef SYNC_CRC_FRAME_PARSER_TOP_ASSERT_SVH
`define SYNC_CRC_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SCFP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/scfp_pkg.sv =====
package scfp_pkg;

    // Sync pattern and CRC-16/CCITT-FALSE constants
    localparam logic [7:0]  SyncFirst  = 8'hA5;
    localparam logic [7:0]  SyncSecond = 8'h5A;
    localparam logic [15:0] CrcPoly    = 16'h1021;
    localparam logic [15:0] CrcInit    = 16'hFFFF;
    localparam logic [15:0] NoneValue  = 16'hFFFF;
    localparam logic [7:0]  BallBit    = 8'h01;
    localparam logic [7:0]  TargetBit  = 8'h10;
    localparam logic [7:0]  TypeReset  = 8'h02;

    // Byte offsets within a frame, counted from the first sync byte
    localparam logic [4:0] PosHunt  = 5'd0;
    localparam logic [4:0] PosSync1 = 5'd1;
    localparam logic [4:0] OffType  = 5'd2;
    localparam logic [4:0] OffFlags = 5'd3;
    localparam logic [4:0] OffId    = 5'd4;
    localparam logic [4:0] OffTs    = 5'd6;
    localparam logic [4:0] OffPos   = 5'd10;
    localparam logic [4:0] OffCx    = 5'd12;
    localparam logic [4:0] OffCy    = 5'd14;
    localparam logic [4:0] OffConf  = 5'd20;
    localparam logic [4:0] OffCand  = 5'd21;
    localparam logic [4:0] OffTpos  = 5'd22;
    localparam logic [4:0] OffCrc   = 5'd24;
    localparam logic [4:0] OffLast  = 5'd25;

    localparam int ResPad = 6;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic [31:0] rejected_total;
        logic [31:0] accepted_total;
        logic [1:0]  available_bits;
        logic [15:0] tgt_pos;
        logic [7:0]  cand_num;
        logic [7:0]  confidence;
        logic [15:0] ball_y;
        logic [15:0] ball_x;
        logic [15:0] position;
        logic [31:0] stamp_ms;
        logic [15:0] frm_num;
        logic [7:0]  flags;
    } result_t;

endpackage

// ===== src/scfp_in_stage.sv =====
module scfp_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte
);

    logic       valid_reg;
    logic [7:0] byte_reg;

    // Stage takes a new word whenever it is empty or draining this cycle
    assign s_ready   = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_byte  = byte_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            byte_reg <= s_byte;
        end
    end

endmodule

// ===== src/scfp_parser.sv =====
`include "sync_crc_frame_parser_top_assert.svh"

module scfp_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        in_byte,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    output logic              res_valid,
    input  logic              res_ready,
    output scfp_pkg::result_t res_data
);

    // Byte-wide CRC-16 update, MSB first
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ scfp_pkg::CrcPoly) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    logic [4:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [31:0] acc_reg, acc_next;
    logic [31:0] rej_reg, rej_next;
    logic [7:0]  exp_type_reg;
    logic        res_valid_reg;
    scfp_pkg::result_t res_reg, res_next;

    // Captured frame bytes
    logic [7:0]  type_reg, flags_reg, conf_reg, cand_reg, crc_lo_reg;
    logic [15:0] id_reg, bpos_reg, cx_reg, cy_reg, tpos_reg;
    logic [31:0] ts_reg;

    logic fire;
    logic frame_end;
    logic frame_ok;
    logic res_load;

    // Result register frees up when empty or being taken
    assign in_ready  = !res_valid_reg || res_ready;
    assign fire      = in_valid && in_ready;
    assign frame_end = fire && (pos_reg == scfp_pkg::OffLast);
    assign frame_ok  = ({in_byte, crc_lo_reg} == crc_reg) && (type_reg == exp_type_reg);
    assign res_load  = frame_end && frame_ok;

    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;

    // Sync hunt, position and running CRC
    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (fire) begin
            priority if (pos_reg == scfp_pkg::PosHunt) begin
                if (in_byte == scfp_pkg::SyncFirst) pos_next = scfp_pkg::PosSync1;
            end else if (pos_reg == scfp_pkg::PosSync1) begin
                if (in_byte == scfp_pkg::SyncSecond) begin
                    pos_next = scfp_pkg::OffType;
                    crc_next = scfp_pkg::CrcInit;
                end else if (in_byte != scfp_pkg::SyncFirst) begin
                    pos_next = scfp_pkg::PosHunt;
                end
            end else if (pos_reg >= scfp_pkg::OffLast) begin
                pos_next = scfp_pkg::PosHunt;
            end else begin
                pos_next = pos_reg + 5'd1;
                if (pos_reg < scfp_pkg::OffCrc) crc_next = crc_feed(crc_reg, in_byte);
            end
        end
    end

    // Counters bump on the last byte of each frame
    always_comb begin
        acc_next = acc_reg;
        rej_next = rej_reg;
        if (frame_end) begin
            if (frame_ok) acc_next = acc_reg + 32'd1;
            else          rej_next = rej_reg + 32'd1;
        end
    end

    // Unpack fields for the result word
    always_comb begin
        res_next.flags           = flags_reg;
        res_next.frm_num         = id_reg;
        res_next.stamp_ms        = ts_reg;
        res_next.position        = bpos_reg;
        res_next.ball_x          = cx_reg;
        res_next.ball_y          = cy_reg;
        res_next.confidence      = conf_reg;
        res_next.cand_num        = cand_reg;
        res_next.tgt_pos         = tpos_reg;
        res_next.available_bits  = {
            ((flags_reg & scfp_pkg::TargetBit) != 8'h00) && (tpos_reg != scfp_pkg::NoneValue),
            ((flags_reg & scfp_pkg::BallBit) != 8'h00) && (bpos_reg != scfp_pkg::NoneValue)};
        res_next.accepted_total  = acc_next;
        res_next.rejected_total  = rej_next;
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= scfp_pkg::PosHunt;
            crc_reg       <= scfp_pkg::CrcInit;
            acc_reg       <= 32'd0;
            rej_reg       <= 32'd0;
            exp_type_reg  <= scfp_pkg::TypeReset;
            res_valid_reg <= 1'b0;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            acc_reg <= acc_next;
            rej_reg <= rej_next;
            if (cfg_wr_en) exp_type_reg <= cfg_wr_data;
            if (in_ready) res_valid_reg <= res_load;
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (res_load) res_reg <= res_next;
    end

    // Frame byte capture by position; positions 0, 1 and unreported bytes fall through
    always_ff @(posedge aclk) begin
        if (fire) begin
            unique case (pos_reg)
                scfp_pkg::OffType:         type_reg        <= in_byte;
                scfp_pkg::OffFlags:        flags_reg       <= in_byte;
                scfp_pkg::OffId:           id_reg[7:0]     <= in_byte;
                scfp_pkg::OffId + 5'd1:    id_reg[15:8]    <= in_byte;
                scfp_pkg::OffTs:           ts_reg[7:0]     <= in_byte;
                scfp_pkg::OffTs + 5'd1:    ts_reg[15:8]    <= in_byte;
                scfp_pkg::OffTs + 5'd2:    ts_reg[23:16]   <= in_byte;
                scfp_pkg::OffTs + 5'd3:    ts_reg[31:24]   <= in_byte;
                scfp_pkg::OffPos:          bpos_reg[7:0]   <= in_byte;
                scfp_pkg::OffPos + 5'd1:   bpos_reg[15:8]  <= in_byte;
                scfp_pkg::OffCx:           cx_reg[7:0]     <= in_byte;
                scfp_pkg::OffCx + 5'd1:    cx_reg[15:8]    <= in_byte;
                scfp_pkg::OffCy:           cy_reg[7:0]     <= in_byte;
                scfp_pkg::OffCy + 5'd1:    cy_reg[15:8]    <= in_byte;
                scfp_pkg::OffConf:         conf_reg        <= in_byte;
                scfp_pkg::OffCand:         cand_reg        <= in_byte;
                scfp_pkg::OffTpos:         tpos_reg[7:0]   <= in_byte;
                scfp_pkg::OffTpos + 5'd1:  tpos_reg[15:8]  <= in_byte;
                scfp_pkg::OffCrc:          crc_lo_reg      <= in_byte;
                default: ;
            endcase
        end
    end

    // Last frame byte always returns the parser to hunting
    `SCFP_ASSERT_NXT(a_end_hunts, aclk, aresetn, frame_end,
        pos_reg == scfp_pkg::PosHunt, "frame end did not return to hunt")
    // A good frame always presents a result next cycle
    `SCFP_ASSERT_NXT(a_ok_result, aclk, aresetn, res_load,
        res_valid_reg && (res_reg.accepted_total == acc_reg), "accepted frame gave no result")
    // Accepted count moves only with a result load
    `SCFP_ASSERT_IMP(a_acc_src, aclk, aresetn, $past(aresetn) && (acc_reg != $past(acc_reg)),
        $past(res_load), "accepted count moved without a result")
    // Rejected count moves only on a failed frame end
    `SCFP_ASSERT_IMP(a_rej_src, aclk, aresetn, $past(aresetn) && (rej_reg != $past(rej_reg)),
        $past(frame_end) && !$past(res_load), "rejected count moved without a rejected frame")

endmodule

// ===== src/sync_crc_frame_parser_top.sv =====
// Path: the final CRC byte lands in the input register and then reaches the parser, which
// loads the result register; the result word is then shown on m_tvalid.
// Throughput: one byte per cycle; the input register and the result register each advance
// whenever the stage behind them is empty or being drained.
// Reset (aresetn low, synchronous): parser hunts for sync, CRC is FFFF, both counts are zero,
// expected type is 2, no word held in either stage.
module sync_crc_frame_parser_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [7:0]   cfg_wr_data,   // expected_type
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,       // rx_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // flags, frm_num, stamp_ms, position, ball_x, ball_y, confidence,
    // cand_num, tgt_pos, available_bits, accepted_total,
    // rejected_total, zero pad
    output logic [207:0] m_tdata
);

    logic              st_valid;
    logic              st_ready;
    logic [7:0]        st_byte;
    scfp_pkg::result_t res;

    // Input register
    scfp_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_tvalid),
        .s_ready   (s_tready),
        .s_byte    (s_tdata),
        .out_valid (st_valid),
        .out_ready (st_ready),
        .out_byte  (st_byte)
    );

    // Frame parser with result register
    scfp_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (st_valid),
        .in_ready    (st_ready),
        .in_byte     (st_byte),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .res_data    (res)
    );

    assign m_tdata = {{scfp_pkg::ResPad{1'b0}}, res};

endmodule
